[sv/ffca_pkg.sv]
// ffca_pkg: shared constants, status codes and sequencer states for the allocator
// no dependencies
package ffca_pkg;

    localparam int HEAP_BYTES_DEF       = 10485760;
    localparam int MAX_FREE_REGIONS_DEF = 64;
    localparam int MAX_LIVE_BLOCKS_DEF  = 64;

    localparam logic [25:0] HDR_BYTES = 26'd8;
    localparam logic [25:0] MIN_SPLIT = 26'd24;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;

    typedef enum logic [16:0] {
        S_INIT = 17'b00000000000000001,
        S_IDLE = 17'b00000000000000010,
        A_RD   = 17'b00000000000000100,
        A_CHK  = 17'b00000000000001000,
        A_LIVE = 17'b00000000000010000,
        A_UPD  = 17'b00000000000100000,
        F_RD   = 17'b00000000001000000,
        F_CHK  = 17'b00000000010000000,
        G_RD   = 17'b00000000100000000,
        G_CHK  = 17'b00000001000000000,
        G_ACT  = 17'b00000010000000000,
        SH_RD  = 17'b00000100000000000,
        SH_WR  = 17'b00001000000000000,
        P_RD   = 17'b00010000000000000,
        P_WR   = 17'b00100000000000000,
        S_DONE = 17'b01000000000000000,
        P_FIN  = 17'b10000000000000000
    } t_state;

endpackage

[sv/ffca_ram.sv]
// ffca_ram: single write port, single registered read port memory
// depends on nothing
module ffca_ram #(
    parameter int W = 48,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/first_fit_coalescing_allocator.sv]
// first_fit_coalescing_allocator: request sequencer over the free-region and live-block memories
// depends on ffca_pkg and ffca_ram
// Allocate scans the free regions, then the live slots, and shifts regions on a drop;
// free scans the live slots, then the free regions, and shifts regions on a merge or
// an insert. One request at a time: the input stalls until the request is done.
// After reset the S_INIT state writes the initial free region.
module first_fit_coalescing_allocator
    import ffca_pkg::*;
#(
    parameter int HEAP_BYTES       = HEAP_BYTES_DEF,
    parameter int MAX_FREE_REGIONS = MAX_FREE_REGIONS_DEF,
    parameter int MAX_LIVE_BLOCKS  = MAX_LIVE_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [23:0] i_req_size,
    input  logic [23:0] i_req_offset,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [23:0] o_alloc_offset
);

    localparam int FA  = $clog2(MAX_FREE_REGIONS);
    localparam int FCW = $clog2(MAX_FREE_REGIONS + 1);
    localparam int LA  = $clog2(MAX_LIVE_BLOCKS);
    localparam int LCW = $clog2(MAX_LIVE_BLOCKS + 1);
    localparam logic [23:0]    HEAP24 = HEAP_BYTES[23:0];
    localparam logic [FCW-1:0] FMAX   = FCW'(MAX_FREE_REGIONS);
    localparam logic [LCW-1:0] LMAX   = LCW'(MAX_LIVE_BLOCKS);

    t_state r_state, n_state;
    logic [23:0] r_size, r_off;
    logic [FCW-1:0] r_i, n_i, r_k, n_k, r_count, n_count;
    logic [LCW-1:0] r_j, n_j;
    logic [23:0] r_s, n_s, r_l, n_l, r_ps, n_ps, r_pl, n_pl, r_cs, n_cs, r_cl, n_cl;
    logic r_hp, n_hp, r_cok, n_cok;
    logic [1:0]  r_st, n_st;
    logic [23:0] r_ao, n_ao;
    logic [MAX_LIVE_BLOCKS-1:0] r_live_valid, n_live_valid;
    logic        r_ov, n_ov;
    logic [1:0]  r_ost, n_ost;
    logic [23:0] r_oao, n_oao;

    logic          f_we, l_we;
    logic [FA-1:0] f_waddr, f_raddr;
    logic [LA-1:0] l_waddr, l_raddr;
    logic [47:0]   f_wdata, f_rdata, l_wdata, l_rdata;

    logic [25:0] need;
    logic [24:0] be;
    logic        mp, mn, accept;

    ffca_ram #(.W(48), .D(MAX_FREE_REGIONS)) u_free (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    ffca_ram #(.W(48), .D(MAX_LIVE_BLOCKS)) u_live (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_rdata)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign accept         = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid    = r_ov;
    assign o_status       = r_ost;
    assign o_alloc_offset = r_oao;

    assign need = {2'b00, r_size} + HDR_BYTES;
    assign be   = {1'b0, r_s} + {1'b0, r_l};
    assign mp   = r_hp && (({1'b0, r_ps} + {1'b0, r_pl}) == {1'b0, r_s});
    assign mn   = r_cok && ({1'b0, r_cs} == be);

    always_comb begin
        n_state = r_state;
        n_i = r_i; n_k = r_k; n_j = r_j; n_count = r_count;
        n_s = r_s; n_l = r_l; n_ps = r_ps; n_pl = r_pl; n_cs = r_cs; n_cl = r_cl;
        n_hp = r_hp; n_cok = r_cok; n_st = r_st; n_ao = r_ao;
        n_live_valid = r_live_valid;
        n_ov = r_ov; n_ost = r_ost; n_oao = r_oao;
        f_we = 1'b0; f_waddr = r_i[FA-1:0]; f_wdata = {r_s, r_l}; f_raddr = r_i[FA-1:0];
        l_we = 1'b0; l_waddr = r_j[LA-1:0]; l_wdata = {r_s, r_l}; l_raddr = r_j[LA-1:0];

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                f_we = 1'b1;
                f_waddr = '0;
                f_wdata = {24'd0, HEAP24};
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    n_i = '0; n_j = '0; n_hp = 1'b0; n_cok = 1'b0; n_ao = '0;
                    n_state = (i_req_type == REQ_ALLOC) ? A_RD : F_RD;
                end
            end
            A_RD: begin
                if (r_i >= r_count) begin
                    n_st = ST_NOFIT;
                    n_state = S_DONE;
                end else begin
                    n_state = A_CHK;
                end
            end
            A_CHK: begin
                if ({2'b00, f_rdata[23:0]} >= need) begin
                    n_s = f_rdata[47:24];
                    n_l = f_rdata[23:0];
                    n_state = A_LIVE;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = A_RD;
                end
            end
            A_LIVE: begin
                if (r_j >= LMAX) begin
                    n_st = ST_FULL;
                    n_state = S_DONE;
                end else if (!r_live_valid[r_j[LA-1:0]]) begin
                    n_state = A_UPD;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            A_UPD: begin
                l_we = 1'b1;
                n_live_valid[r_j[LA-1:0]] = 1'b1;
                n_st = ST_OK;
                n_ao = r_s + 24'd8;
                if ({2'b00, r_l} >= need + MIN_SPLIT) begin
                    f_we = 1'b1;
                    f_wdata = {r_s + need[23:0], r_l - need[23:0]};
                    l_wdata = {r_s, need[23:0]};
                    n_state = S_DONE;
                end else begin
                    n_k = r_i;
                    n_state = SH_RD;
                end
            end
            F_RD: begin
                if (r_j >= LMAX) begin
                    n_st = ST_UNKNOWN;
                    n_state = S_DONE;
                end else if (!r_live_valid[r_j[LA-1:0]]) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_state = F_CHK;
                end
            end
            F_CHK: begin
                if (({1'b0, l_rdata[47:24]} + 25'd8) == {1'b0, r_off}) begin
                    n_s = l_rdata[47:24];
                    n_l = l_rdata[23:0];
                    n_state = G_RD;
                end else begin
                    n_j = r_j + 1'b1;
                    n_state = F_RD;
                end
            end
            G_RD: begin
                if (r_i < r_count) begin
                    n_state = G_CHK;
                end else begin
                    n_cok = 1'b0;
                    n_state = G_ACT;
                end
            end
            G_CHK: begin
                if (f_rdata[47:24] < r_s) begin
                    n_ps = f_rdata[47:24];
                    n_pl = f_rdata[23:0];
                    n_hp = 1'b1;
                    n_i = r_i + 1'b1;
                    n_state = G_RD;
                end else begin
                    n_cs = f_rdata[47:24];
                    n_cl = f_rdata[23:0];
                    n_cok = 1'b1;
                    n_state = G_ACT;
                end
            end
            G_ACT: begin
                n_st = ST_OK;
                n_state = S_DONE;
                if (mp) begin
                    f_we = 1'b1;
                    f_waddr = FA'(r_i - 1'b1);
                    if (mn) begin
                        f_wdata = {r_ps, r_pl + r_l + r_cl};
                        n_k = r_i;
                        n_state = SH_RD;
                    end else begin
                        f_wdata = {r_ps, r_pl + r_l};
                    end
                    n_live_valid[r_j[LA-1:0]] = 1'b0;
                end else if (mn) begin
                    f_we = 1'b1;
                    f_wdata = {r_s, r_cl + r_l};
                    n_live_valid[r_j[LA-1:0]] = 1'b0;
                end else if (r_count >= FMAX) begin
                    n_st = ST_FULL;
                end else begin
                    n_live_valid[r_j[LA-1:0]] = 1'b0;
                    n_k = r_count;
                    n_state = P_RD;
                end
            end
            SH_RD: begin
                f_raddr = FA'(r_k + 1'b1);
                if ((r_k + 1'b1) < r_count) begin
                    n_state = SH_WR;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            SH_WR: begin
                f_we = 1'b1;
                f_waddr = r_k[FA-1:0];
                f_wdata = f_rdata;
                n_k = r_k + 1'b1;
                n_state = SH_RD;
            end
            P_RD: begin
                f_raddr = FA'(r_k - 1'b1);
                n_state = (r_k > r_i) ? P_WR : P_FIN;
            end
            P_WR: begin
                f_we = 1'b1;
                f_waddr = r_k[FA-1:0];
                f_wdata = f_rdata;
                n_k = r_k - 1'b1;
                n_state = P_RD;
            end
            P_FIN: begin
                f_we = 1'b1;
                f_wdata = {r_s, r_l};
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov = 1'b1;
                    n_ost = r_st;
                    n_oao = (r_st == ST_OK) ? r_ao : 24'd0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_count      <= FCW'(1);
            r_live_valid <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_live_valid <= n_live_valid;
            r_ov         <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_size <= i_req_size;
            r_off  <= i_req_offset;
        end
        r_i <= n_i; r_k <= n_k; r_j <= n_j;
        r_s <= n_s; r_l <= n_l; r_ps <= n_ps; r_pl <= n_pl; r_cs <= n_cs; r_cl <= n_cl;
        r_hp <= n_hp; r_cok <= n_cok; r_st <= n_st; r_ao <= n_ao;
        r_ost <= n_ost; r_oao <= n_oao;
    end

endmodule

[tb/first_fit_coalescing_allocator_test.sv]
// first_fit_coalescing_allocator_test: random and directed allocate/free traffic with a
// scoreboard that mirrors the free-region and live-block tables
// depends on ffca_pkg and the allocator rtl
module first_fit_coalescing_allocator_test
    import ffca_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP = HEAP_BYTES_DEF;
    localparam int NFREE = MAX_FREE_REGIONS_DEF;
    localparam int NLIVE = MAX_LIVE_BLOCKS_DEF;
    localparam logic REQ_FREE = 1'b1;
    localparam int LIMIT = 4000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] offset;
    } t_reply;

    class heap_scoreboard;
        int unsigned fstart[NFREE];
        int unsigned flen[NFREE];
        int unsigned fcount;
        int unsigned lstart[NLIVE];
        int unsigned llen[NLIVE];
        bit          lvalid[NLIVE];
        t_reply      pending[$];
        int          errors;

        function new();
            fcount = 1;
            fstart[0] = 0;
            flen[0] = HEAP;
            foreach (lvalid[k]) lvalid[k] = 0;
            errors = 0;
        endfunction

        function void drop_at(int unsigned p);
            for (int unsigned k = p; k + 1 < fcount; k++) begin
                fstart[k] = fstart[k+1];
                flen[k] = flen[k+1];
            end
            fcount--;
        endfunction

        function t_reply allocate(int unsigned size);
            t_reply r;
            int unsigned need, i, j, s, l;
            r = '0;
            need = size + 8;
            for (i = 0; i < fcount; i++) if (flen[i] >= need) break;
            if (i >= fcount) begin
                r.status = ST_NOFIT;
                return r;
            end
            for (j = 0; j < NLIVE; j++) if (!lvalid[j]) break;
            if (j >= NLIVE) begin
                r.status = ST_FULL;
                return r;
            end
            s = fstart[i];
            l = flen[i];
            if (l >= need + 24) begin
                fstart[i] = (s + need) & 24'hFFFFFF;
                flen[i] = l - need;
                llen[j] = need;
            end else begin
                drop_at(i);
                llen[j] = l;
            end
            lstart[j] = s;
            lvalid[j] = 1;
            r.status = ST_OK;
            r.offset = 24'(s + 8);
            return r;
        endfunction

        function t_reply release_block(int unsigned off);
            t_reply r;
            int unsigned j, i, bs, bl;
            bit mp, mn;
            r = '0;
            for (j = 0; j < NLIVE; j++) if (lvalid[j] && lstart[j] + 8 == off) break;
            if (j >= NLIVE) begin
                r.status = ST_UNKNOWN;
                return r;
            end
            bs = lstart[j];
            bl = llen[j];
            i = 0;
            while (i < fcount && fstart[i] < bs) i++;
            mp = i > 0 && fstart[i-1] + flen[i-1] == bs;
            mn = i < fcount && fstart[i] == bs + bl;
            if (!mp && !mn && fcount >= NFREE) begin
                r.status = ST_FULL;
                return r;
            end
            if (mp && mn) begin
                flen[i-1] = flen[i-1] + bl + flen[i];
                drop_at(i);
            end else if (mp) begin
                flen[i-1] += bl;
            end else if (mn) begin
                fstart[i] = bs;
                flen[i] += bl;
            end else begin
                for (int unsigned k = fcount; k > i; k--) begin
                    fstart[k] = fstart[k-1];
                    flen[k] = flen[k-1];
                end
                fstart[i] = bs;
                flen[i] = bl;
                fcount++;
            end
            lvalid[j] = 0;
            r.status = ST_OK;
            return r;
        endfunction

        function void note_request(logic kind, logic [23:0] size, logic [23:0] off);
            t_reply e;
            e = (kind == REQ_ALLOC) ? allocate(size) : release_block(off);
            pending = {pending, e};
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_reply(logic [1:0] st, logic [23:0] off);
            t_reply e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected word status %0d offset %0d", st, off));
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
                report($sformatf("status %0d, wanted %0d", st, e.status));
            if (off !== e.offset)
                report($sformatf("offset %0d, wanted %0d", off, e.offset));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic        i_req_type = 0;
    logic [23:0] i_req_size = 0;
    logic [23:0] i_req_offset = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [1:0]  o_status;
    logic [23:0] o_alloc_offset;

    heap_scoreboard board = new();
    int cycles = 0;
    bit hold_long = 0;

    first_fit_coalescing_allocator uut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** first_fit_coalescing_allocator: FAILED **");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_reply(o_status, o_alloc_offset);
    end

    // receiver: random stall per word, plus one long hold
    initial begin
        int w;
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                i_out_stall <= 1;
                repeat (3000) @(negedge i_clk);
                hold_long = 0;
                i_out_stall <= 0;
            end else begin
                w = $urandom_range(0, 4);
                if (w != 0) begin
                    i_out_stall <= 1;
                    repeat (w) @(negedge i_clk);
                end
                i_out_stall <= 0;
                @(posedge i_clk);
                while (!o_out_valid) @(posedge i_clk);
            end
        end
    end

    task automatic send(logic kind, logic [23:0] size, logic [23:0] off, bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            i_in_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_req_type <= kind;
        i_req_size <= size;
        i_req_offset <= off;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_request(kind, size, off);
        @(negedge i_clk);
    endtask

    function automatic logic [23:0] live_offset();
        int unsigned picks[$];
        foreach (board.lvalid[k]) if (board.lvalid[k]) picks = {picks, board.lstart[k] + 8};
        if (picks.size() == 0) return 24'($urandom);
        return 24'(picks[$urandom_range(0, picks.size() - 1)]);
    endfunction

    initial begin
        int r;
        logic [23:0] sz;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed
        send(REQ_ALLOC, 24'd0, 24'hFFFFFF, 1'b0);
        send(REQ_ALLOC, 24'd16, 24'd0, 1'b0);
        send(REQ_ALLOC, 24'hFFFFFF, 24'd0, 1'b0);
        send(REQ_ALLOC, 24'(HEAP), 24'd0, 1'b0);
        send(REQ_FREE, 24'hFFFFFF, 24'd8, 1'b0);
        send(REQ_FREE, 24'd0, 24'd8, 1'b0);
        send(REQ_FREE, 24'd0, 24'd8, 1'b0);
        send(REQ_FREE, 24'd0, 24'hFFFFFF, 1'b0);
        send(REQ_FREE, 24'd0, 24'd32, 1'b0);
        send(REQ_ALLOC, 24'(HEAP - 8), 24'd0, 1'b0);
        send(REQ_ALLOC, 24'd0, 24'd0, 1'b0);
        send(REQ_FREE, 24'd0, 24'd8, 1'b0);
        // fill the live table, then free every other block to add regions to the free table
        for (int k = 0; k < NLIVE + 2; k++) send(REQ_ALLOC, 24'(k * 8), 24'd0, 1'b1);
        for (int k = 0; k < NLIVE; k += 2)
            send(REQ_FREE, 24'd0, 24'(board.lstart[k] + 8), 1'b1);
        hold_long = 1;
        for (int k = 0; k < 40; k++)
            send(REQ_ALLOC, 24'($urandom_range(0, 64)), 24'd0, 1'b0);
        // random
        for (int n = 0; n < 1400; n++) begin
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0: sz = 24'($urandom);
                1: sz = 24'($urandom_range(HEAP / 4, HEAP));
                default: sz = 24'($urandom_range(0, 200));
            endcase
            if (r < 50) send(REQ_ALLOC, sz, 24'($urandom), 1'b1);
            else if (r < 92) send(REQ_FREE, 24'($urandom), live_offset(), 1'b1);
            else send(REQ_FREE, sz, 24'($urandom), 1'b1);
        end
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (board.errors == 0)
            $display("** first_fit_coalescing_allocator: PASSED **");
        else
            $display("** first_fit_coalescing_allocator: FAILED **");
        $finish;
    end
endmodule
